FILE: sv/zpbh_pkg.sv
// Shared types, constants and helpers for the zero page bloat histogram.
`timescale 1ns / 1ps

package zpbh_pkg;

  localparam int WORDS_PER_PAGE = 512;
  localparam int PAGES_PER_HUGE = 512;
  localparam int NUM_BINS       = 11;
  localparam int FIFO_DEPTH     = 4;

  localparam int WORD_W  = (WORDS_PER_PAGE > 1) ? $clog2(WORDS_PER_PAGE) : 1;
  localparam int PAGE_W  = (PAGES_PER_HUGE > 1) ? $clog2(PAGES_PER_HUGE) : 1;
  localparam int ZCNT_W  = 10;
  localparam int BIN_W   = 4;
  localparam int CNT_W   = 32;
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FILL_W  = $clog2(FIFO_DEPTH + 1);
  localparam int PROD_W  = ZCNT_W + 4;

  typedef enum logic [1:0] {
    FUNC_DATA  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_code_t;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  typedef struct packed {
    op_code_t            code;
    logic [ZCNT_W-1:0]   zeros;
    logic [BIN_W-1:0]    idx;
  } op_t;

  // floor(floor(z*100/P)/10) == floor(z*10/P); P is a power of two here
  function automatic logic [BIN_W-1:0] bin_of(input logic [ZCNT_W-1:0] zeros);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] q;
    begin
      prod = PROD_W'(zeros) * PROD_W'(10);
      q    = prod / PROD_W'(PAGES_PER_HUGE);
      if (q >= PROD_W'(NUM_BINS)) begin
        bin_of = BIN_W'(NUM_BINS - 1);
      end else begin
        bin_of = q[BIN_W-1:0];
      end
    end
  endfunction

endpackage

FILE: sv/zero_page_bloat_histogram_unit.sv
// An accepted request reaches out_valid through the op queue, then the output register.
// Throughput: one request per cycle while in_ready is high; reads, clears and the last word
// of a huge page take a queue slot. in_ready drops once four ops wait behind a stalled output.
// Reset (synchronous, active high) zeroes page/word position, zero count and all bins.
// Top level of the zero page bloat histogram.
`timescale 1ns / 1ps

module zero_page_bloat_histogram_unit
  import zpbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [63:0]       data_word,
  input  logic [BIN_W-1:0]  bin_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [ZCNT_W-1:0] zero_pages,
  output logic [BIN_W-1:0]  bin,
  output logic [CNT_W-1:0]  bin_count
);

  logic fifo_full;
  logic fifo_empty;
  logic push;
  logic pop;
  op_t  push_op;
  op_t  head;

  zpbh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_word (data_word),
    .bin_index (bin_index),
    .fifo_full (fifo_full),
    .push      (push),
    .push_op   (push_op)
  );

  zpbh_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (fifo_full),
    .pop     (pop),
    .head    (head),
    .empty   (fifo_empty)
  );

  zpbh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (fifo_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .zero_pages (zero_pages),
    .bin        (bin),
    .bin_count  (bin_count)
  );

endmodule

FILE: sv/zpbh_front.sv
// Front end: takes requests, tracks page position, classifies into ops.
`timescale 1ns / 1ps

module zpbh_front
  import zpbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [63:0]       data_word,
  input  logic [BIN_W-1:0]  bin_index,
  input  logic              fifo_full,
  output logic              push,
  output op_t               push_op
);

  logic [WORD_W-1:0] word_in_page, word_in_page_next;
  logic [PAGE_W-1:0] page_in_huge, page_in_huge_next;
  logic              page_nonzero_seen, page_nonzero_seen_next;
  logic [ZCNT_W-1:0] zero_page_count, zero_page_count_next;

  logic              accept;
  logic              nz;
  logic              last_word;
  logic              last_page;
  logic [ZCNT_W-1:0] zeros_final;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  assign nz          = page_nonzero_seen || (data_word != 64'd0);
  assign last_word   = (word_in_page == WORD_W'(WORDS_PER_PAGE - 1));
  assign last_page   = (page_in_huge == PAGE_W'(PAGES_PER_HUGE - 1));
  assign zeros_final = zero_page_count + ZCNT_W'(!nz);

  always_comb begin
    word_in_page_next      = word_in_page;
    page_in_huge_next      = page_in_huge;
    page_nonzero_seen_next = page_nonzero_seen;
    zero_page_count_next   = zero_page_count;
    push                   = 1'b0;
    push_op.code           = OP_UPDATE;
    push_op.zeros          = zeros_final;
    push_op.idx            = bin_index;
    if (accept) begin
      case (func)
        FUNC_DATA: begin
          if (!last_word) begin
            word_in_page_next      = word_in_page + WORD_W'(1);
            page_nonzero_seen_next = nz;
          end else begin
            word_in_page_next      = '0;
            page_nonzero_seen_next = 1'b0;
            if (!last_page) begin
              page_in_huge_next    = page_in_huge + PAGE_W'(1);
              zero_page_count_next = zeros_final;
            end else begin
              page_in_huge_next    = '0;
              zero_page_count_next = '0;
              push                 = 1'b1;
            end
          end
        end
        FUNC_READ: begin
          push         = 1'b1;
          push_op.code = OP_READ;
        end
        FUNC_CLEAR: begin
          push         = 1'b1;
          push_op.code = OP_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_in_page      <= '0;
      page_in_huge      <= '0;
      page_nonzero_seen <= 1'b0;
      zero_page_count   <= '0;
    end else begin
      word_in_page      <= word_in_page_next;
      page_in_huge      <= page_in_huge_next;
      page_nonzero_seen <= page_nonzero_seen_next;
      zero_page_count   <= zero_page_count_next;
    end
  end

endmodule

FILE: sv/zpbh_fifo.sv
// Short op queue between the front end and the histogram back end.
`timescale 1ns / 1ps

module zpbh_fifo
  import zpbh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  head,
  output logic empty
);

  op_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full  = (fill == FILL_W'(FIFO_DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + FILL_W'(push) - FILL_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("op queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("op queue read while empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(FIFO_DEPTH))
    else $error("op queue fill count out of range");
`endif

endmodule

FILE: sv/zpbh_back.sv
// Back end: histogram storage, update, readout and clear; output register.
`timescale 1ns / 1ps

module zpbh_back
  import zpbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  op_t               head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [ZCNT_W-1:0] zero_pages,
  output logic [BIN_W-1:0]  bin,
  output logic [CNT_W-1:0]  bin_count
);

  logic [CNT_W-1:0] hist [NUM_BINS];

  logic [BIN_W-1:0] upd_bin;
  logic [CNT_W-1:0] upd_cur;
  logic [CNT_W-1:0] upd_cnt;
  logic [CNT_W-1:0] rd_cnt;

  assign pop = !empty && (!out_valid || out_ready);

  assign upd_bin = bin_of(head.zeros);
  assign upd_cur = hist[upd_bin];
  // saturating increment
  assign upd_cnt = (upd_cur == {CNT_W{1'b1}}) ? upd_cur : upd_cur + CNT_W'(1);
  assign rd_cnt  = (head.idx < BIN_W'(NUM_BINS)) ? hist[head.idx] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        hist[i] <= '0;
      end
    end else if (pop) begin
      case (head.code)
        OP_UPDATE: hist[upd_bin] <= upd_cnt;
        OP_CLEAR: begin
          for (int i = 0; i < NUM_BINS; i++) begin
            hist[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= (head.code == OP_UPDATE) || (head.code == OP_READ);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head.code)
        OP_UPDATE: begin
          kind       <= KIND_SUMMARY;
          zero_pages <= head.zeros;
          bin        <= upd_bin;
          bin_count  <= upd_cnt;
        end
        OP_READ: begin
          kind       <= KIND_READOUT;
          zero_pages <= '0;
          bin        <= head.idx;
          bin_count  <= rd_cnt;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    pop && (head.code == OP_CLEAR) |=> (hist[0] == '0) && (hist[NUM_BINS-1] == '0))
    else $error("histogram not cleared");

  a_summary_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_SUMMARY) |-> (bin_count != '0))
    else $error("summary reports an empty bin");

  a_summary_bin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_SUMMARY) |-> (bin < BIN_W'(NUM_BINS)))
    else $error("summary bin out of range");

  a_readout_oob: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_READOUT) && (bin >= BIN_W'(NUM_BINS))
      |-> (bin_count == '0) && (zero_pages == '0))
    else $error("out of range readout not zero");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the zero page bloat histogram unit.
`timescale 1ns / 1ps

module testbench;
  import zpbh_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_PCT        = 26;
  localparam int RESULT_LATENCY  = 2;
  localparam int RESET_CYCLES    = 12;
  localparam int DRAIN_LIMIT     = 20000;

  typedef struct packed {
    logic              kind;
    logic [ZCNT_W-1:0] zero_pages;
    logic [BIN_W-1:0]  bin;
    logic [CNT_W-1:0]  bin_count;
  } bin_report_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [1:0]        func       = 2'd0;
  logic [63:0]       data_word  = 64'd0;
  logic [BIN_W-1:0]  bin_index  = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic              kind;
  logic [ZCNT_W-1:0] zero_pages;
  logic [BIN_W-1:0]  bin;
  logic [CNT_W-1:0]  bin_count;

  // predicted scan position and histogram
  int unsigned       word_pos;
  int unsigned       page_pos;
  int unsigned       zero_pages_seen;
  bit                page_dirty;
  logic [CNT_W-1:0]  bin_counts [NUM_BINS];

  bin_report_t       bin_reports_due [$];
  bin_report_t       report_now;
  int                errors      = 0;
  bit                no_idle     = 1'b0;
  int                hold_cycles = 0;

  zero_page_bloat_histogram_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #200_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Advance the predicted scan state for one accepted request.
  function automatic void predict_request(input logic [1:0] f, input logic [63:0] w,
                                          input logic [BIN_W-1:0] idx);
    bin_report_t r;
    int unsigned b;
    bit          nz;
    case (f)
      FUNC_DATA: begin
        nz = page_dirty || (w != 64'd0);
        if (word_pos + 1 < WORDS_PER_PAGE) begin
          word_pos++;
          page_dirty = nz;
        end else begin
          word_pos   = 0;
          page_dirty = 1'b0;
          if (!nz) zero_pages_seen++;
          if (page_pos + 1 < PAGES_PER_HUGE) begin
            page_pos++;
          end else begin
            b = ((zero_pages_seen * 100) / PAGES_PER_HUGE) / 10;
            if (b >= NUM_BINS) b = NUM_BINS - 1;
            if (bin_counts[b] != '1) bin_counts[b]++;
            r.kind       = KIND_SUMMARY;
            r.zero_pages = zero_pages_seen[ZCNT_W-1:0];
            r.bin        = b[BIN_W-1:0];
            r.bin_count  = bin_counts[b];
            page_pos        = 0;
            zero_pages_seen = 0;
            bin_reports_due.push_back(r);
          end
        end
      end
      FUNC_READ: begin
        r.kind       = KIND_READOUT;
        r.zero_pages = '0;
        r.bin        = idx;
        r.bin_count  = (idx < NUM_BINS) ? bin_counts[idx] : '0;
        bin_reports_due.push_back(r);
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < NUM_BINS; i++) bin_counts[i] = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] nonzero_word();
    logic [63:0] w;
    case ($urandom_range(0, 3))
      0: w = 64'd1 << $urandom_range(0, 63);
      1: w = '1;
      default: begin
        w = {$urandom, $urandom};
        if (w == 64'd0) w = 64'd1;
      end
    endcase
    return w;
  endfunction

  task automatic send_request(input logic [1:0] f, input logic [63:0] w,
                              input logic [BIN_W-1:0] idx);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    data_word <= w;
    bin_index <= idx;
    do @(posedge clk); while (!in_ready);
    predict_request(f, w, idx);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (bin_reports_due.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic send_random_command();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      send_request(FUNC_READ, {$urandom, $urandom}, BIN_W'($urandom_range(0, 15)));
    end else if (pick < 90) begin
      send_request(FUNC_CLEAR, {$urandom, $urandom}, BIN_W'($urandom_range(0, 15)));
    end else begin
      send_request(FUNC_UNUSED, {$urandom, $urandom}, BIN_W'($urandom_range(0, 15)));
    end
  endtask

  // A run of data words; commands are mixed in at about one per cmd_gap words.
  task automatic scan_words(input int n_words, input int zero_pct, input int cmd_gap);
    bit          zero_page;
    logic [63:0] w;
    zero_page = 1'b1;
    for (int i = 0; i < n_words; i++) begin
      if (i == 0 || word_pos == 0) zero_page = ($urandom_range(0, 99) < zero_pct);
      w = 64'd0;
      // the nonzero word often sits on the last word of the small page
      if (!zero_page && (word_pos == WORDS_PER_PAGE - 1 || $urandom_range(0, 63) == 0)) begin
        w = nonzero_word();
      end
      send_request(FUNC_DATA, w, BIN_W'($urandom_range(0, 15)));
      if (cmd_gap != 0 && $urandom_range(1, cmd_gap) == 1) send_random_command();
    end
  endtask

  task automatic test_commands_after_reset();
    send_request(FUNC_READ, 64'd0, BIN_W'(0));
    send_request(FUNC_READ, '1, BIN_W'(5));
    send_request(FUNC_READ, 64'd0, BIN_W'(NUM_BINS - 1));
    send_request(FUNC_READ, 64'd0, BIN_W'(NUM_BINS));
    send_request(FUNC_READ, '1, BIN_W'(15));
    send_request(FUNC_UNUSED, '1, BIN_W'(3));
    send_request(FUNC_CLEAR, '1, '1);
    send_request(FUNC_READ, 64'd0, BIN_W'(NUM_BINS - 1));
    send_request(FUNC_READ, 64'd0, BIN_W'(12));
    wait_results_drained();
  endtask

  // One whole all-zero small page, sent back to back on both sides.
  task automatic test_zero_page_run();
    no_idle = 1'b1;
    scan_words(WORDS_PER_PAGE, 100, 0);
    wait_results_drained();
    no_idle = 1'b0;
    send_request(FUNC_READ, 64'd0, BIN_W'(NUM_BINS - 1));
    wait_results_drained();
  endtask

  task automatic test_mixed_words();
    scan_words(200, $urandom_range(20, 95), 8);
    wait_results_drained();
  endtask

  task automatic test_sparse_words();
    scan_words(40, $urandom_range(0, 8), 10);
    wait_results_drained();
  endtask

  // Receiver holds off while reads keep coming, so the op queue fills.
  task automatic test_output_stall();
    hold_cycles = 80;
    repeat (16) send_request(FUNC_READ, {$urandom, $urandom}, BIN_W'($urandom_range(0, 15)));
    wait_results_drained();
  endtask

  task automatic test_final_readback();
    for (int i = 0; i < 16; i++) send_request(FUNC_READ, 64'd0, BIN_W'(i));
    send_request(FUNC_CLEAR, 64'd0, '0);
    for (int i = 0; i < 16; i++) send_request(FUNC_READ, 64'd0, BIN_W'(i));
    wait_results_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (bin_reports_due.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, actual kind %0d bin %0d",
                 $time, kind, bin);
        errors++;
      end else begin
        report_now = bin_reports_due.pop_front();
        check_field("kind", report_now.kind, kind);
        check_field("zero_pages", report_now.zero_pages, zero_pages);
        check_field("bin", report_now.bin, bin);
        check_field("bin_count", report_now.bin_count, bin_count);
      end
    end
  end

  initial begin
    int waited;
    word_pos        = 0;
    page_pos        = 0;
    zero_pages_seen = 0;
    page_dirty      = 1'b0;
    for (int i = 0; i < NUM_BINS; i++) bin_counts[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_commands_after_reset();
    test_zero_page_run();
    test_mixed_words();
    test_output_stall();
    test_sparse_words();
    test_final_readback();

    waited = 0;
    while (bin_reports_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (RESULT_LATENCY + 8) @(posedge clk);
    if (bin_reports_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, bin_reports_due.size());
    end
    if (errors == 0 && bin_reports_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
